// File: hdl/mtn_pkg.sv
// Shared constants and codes for the match threshold NMS block.
`default_nettype none
package mtn_pkg;
    localparam int FIELD_W = 12;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 17;
    localparam int IDATA_W = 64;
    localparam int ODATA_W = 48;
    localparam int OUSER_W = 2;

    localparam logic signed [SCORE_W-1:0] SCORE_THR_RST = 16'sd13107;
    localparam logic [THR_W-1:0]          IOU_THR_RST   = 17'd32768;

    typedef enum logic {
        CFG_SCORE_THR = 1'b0,
        CFG_IOU_THR   = 1'b1
    } cfg_idx_t;
endpackage
`default_nettype wire

// File: hdl/mtn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mtn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/mtn_mul.sv
// Shared unsigned multiplier with registered product.
`default_nettype none
module mtn_mul #(
    parameter int WIDTH = 27
) (
    input  wire logic               aclk,
    input  wire logic [WIDTH-1:0]   a,
    input  wire logic [WIDTH-1:0]   b,
    output logic      [2*WIDTH-1:0] p
);
    always_ff @(posedge aclk) begin
        p <= a * b;
    end
endmodule
`default_nettype wire

// File: hdl/match_threshold_nms.sv
// Top level: point collection, greedy IoU suppression sequencer and result output.
//
// Input channel s_*: one match point per transfer; s_tlast marks the frame's last
// point. While a frame is collected, s_tready is high and a point is taken every
// cycle. A point whose score is strictly above score_threshold is stored, up to
// MAX_BOXES; further ones set the overflow flag.
// After s_tlast the block drops s_tready and runs suppression on one shared
// multiplier and one store read port. Each round scans all n stored boxes to pick
// the best remaining one, loads it, then tests every stored box against it,
// skipping the dead ones. s_tready returns once the frame's final result is
// loaded into the output register, and that load can wait on m_tready.
// Output channel m_*: one transfer per kept box in descending score order, or a
// single empty result (m_tuser[0] low); m_tlast marks the frame's final result.
// A stall on m_tready holds the output register and pauses the sequencer.
// Reset clears the box count, overflow flag and output valid and restores the
// register defaults; the store and the alive flags need no clearing.
`default_nettype none
module match_threshold_nms #(
    parameter int MAX_BOXES  = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, match_score, template_width, template_height
    input  wire logic [mtn_pkg::IDATA_W-1:0]     s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // box_x, box_y, box_w, box_h
    output logic      [mtn_pkg::ODATA_W-1:0]     m_tdata,
    // box_valid, overflow
    output logic      [mtn_pkg::OUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_idx,
    input  wire logic [mtn_pkg::THR_W-1:0]       cfg_wdata
);
    import mtn_pkg::*;

    localparam int CB   = FIELD_W;
    localparam int EW   = CB + 1;
    localparam int AW   = 2 * EW;
    localparam int UW   = AW + 1;
    localparam int MW   = UW;
    localparam int PW   = 2 * MW;
    localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int RW   = 4 * CB + SCORE_W;

    typedef enum logic [3:0] {
        S_COLLECT, S_SEL_RD, S_SEL_CMP, S_SEL_DONE, S_PICK_RD, S_PICK_LD,
        S_SUP_AREA, S_SUP_RD, S_SUP_GEO, S_SUP_M1, S_SUP_M2, S_SUP_M3, S_SUP_CMP
    } state_t;

    state_t                     state_reg;
    logic signed [SCORE_W-1:0]  score_thr_reg;
    logic [THR_W-1:0]           iou_thr_reg;
    logic [CNTW-1:0]            count_reg;
    logic [CNTW-1:0]            j_reg;
    logic                       ovf_reg;
    logic                       found_reg;
    logic signed [SCORE_W-1:0]  best_score_reg;
    logic [IW-1:0]              best_idx_reg;
    logic                       have_prev_reg;
    logic [CB-1:0]              px_reg, py_reg, pw_reg, ph_reg;
    logic [AW-1:0]              area_a_reg, area_b_reg, inter_reg;
    logic [UW-1:0]              uni_reg;
    logic [EW-1:0]              ox_reg, oy_reg;
    logic                       m_tvalid_reg, m_tlast_reg, m_bv_reg, m_ovf_reg;
    logic [FIELD_W-1:0]         mx_reg, my_reg, mw_reg, mh_reg;

    logic [CB-1:0]              in_x, in_y, in_w, in_h;
    logic signed [SCORE_W-1:0]  in_score;
    logic                       in_acc, in_keep, ram_we;
    logic [IW-1:0]              raddr;
    logic [RW-1:0]              wdata, rdata;
    logic [CB-1:0]              rd_x, rd_y, rd_w, rd_h;
    logic signed [SCORE_W-1:0]  rd_score;
    logic [MW-1:0]              mul_a, mul_b;
    logic [PW-1:0]              prod;
    logic                       out_free, out_load;
    logic [PW-1:0]              lhs, rhs;
    logic                       alive_we, alive_wdata, alive_rd;
    logic [IW-1:0]              alive_waddr;

    function automatic logic [EW-1:0] overlap(input logic [CB-1:0] a0, input logic [CB-1:0] as,
                                              input logic [CB-1:0] b0, input logic [CB-1:0] bs);
        logic [CB:0]   a1, b1, lo, hi;
        logic [CB+1:0] hp;
        a1 = {1'b0, a0} + {1'b0, as};
        b1 = {1'b0, b0} + {1'b0, bs};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (a1 < b1) ? a1 : b1;
        hp = {1'b0, hi} + (CB+2)'(1);
        return (hp > {1'b0, lo}) ? EW'(hp - {1'b0, lo}) : '0;
    endfunction

    assign in_x     = CB'(s_tdata[11:0]);
    assign in_y     = CB'(s_tdata[23:12]);
    assign in_score = s_tdata[39:24];
    assign in_w     = CB'(s_tdata[51:40]);
    assign in_h     = CB'(s_tdata[63:52]);
    assign in_acc   = s_tvalid && s_tready;
    assign in_keep  = in_score > score_thr_reg;
    assign ram_we   = in_acc && in_keep && (count_reg < CNTW'(MAX_BOXES));
    assign wdata    = {in_score, in_h, in_w, in_y, in_x};

    assign {rd_score, rd_h, rd_w, rd_y, rd_x} = rdata;
    assign raddr    = (state_reg == S_PICK_RD) ? best_idx_reg : j_reg[IW-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_SEL_DONE) && out_free && (!found_reg || have_prev_reg);
    assign s_tready = (state_reg == S_COLLECT);

    assign alive_we    = ram_we || (state_reg == S_PICK_LD) ||
                         ((state_reg == S_SUP_CMP) && (lhs >= rhs));
    assign alive_waddr = (state_reg == S_PICK_LD) ? best_idx_reg :
                         (state_reg == S_COLLECT) ? count_reg[IW-1:0] : j_reg[IW-1:0];
    assign alive_wdata = (state_reg == S_COLLECT);

    mtn_ram #(.WIDTH(RW), .DEPTH(MAX_BOXES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mtn_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_alive (
        .aclk  (aclk),
        .we    (alive_we),
        .waddr (alive_waddr),
        .wdata (alive_wdata),
        .raddr (raddr),
        .rdata (alive_rd)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PICK_LD, S_SUP_GEO: begin
                mul_a = MW'(rd_w) + MW'(1);
                mul_b = MW'(rd_h) + MW'(1);
            end
            S_SUP_M1: begin
                mul_a = MW'(ox_reg);
                mul_b = MW'(oy_reg);
            end
            S_SUP_M3: begin
                mul_a = MW'(iou_thr_reg);
                mul_b = MW'(uni_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mtn_mul #(.WIDTH(MW)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign lhs = PW'({inter_reg, 16'h0000});
    assign rhs = prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_COLLECT;
            score_thr_reg  <= SCORE_THR_RST;
            iou_thr_reg    <= IOU_THR_RST;
            count_reg      <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            found_reg      <= 1'b0;
            have_prev_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_SCORE_THR: score_thr_reg <= cfg_wdata[SCORE_W-1:0];
                    CFG_IOU_THR:   iou_thr_reg   <= cfg_wdata;
                    default:       iou_thr_reg   <= iou_thr_reg;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_COLLECT: begin
                    if (in_acc) begin
                        if (ram_we) begin
                            count_reg <= count_reg + CNTW'(1);
                        end else if (in_keep) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            j_reg     <= '0;
                            found_reg <= 1'b0;
                            state_reg <= S_SEL_RD;
                        end
                    end
                end
                S_SEL_RD: begin
                    state_reg <= (j_reg == count_reg) ? S_SEL_DONE : S_SEL_CMP;
                end
                S_SEL_CMP: begin
                    if (alive_rd && (!found_reg || rd_score > best_score_reg)) begin
                        best_score_reg <= rd_score;
                        best_idx_reg   <= j_reg[IW-1:0];
                        found_reg      <= 1'b1;
                    end
                    j_reg     <= j_reg + CNTW'(1);
                    state_reg <= S_SEL_RD;
                end
                S_SEL_DONE: begin
                    if (!found_reg) begin
                        if (out_free) begin
                            m_tlast_reg   <= 1'b1;
                            m_bv_reg      <= have_prev_reg;
                            m_ovf_reg     <= ovf_reg;
                            mx_reg        <= have_prev_reg ? FIELD_W'(px_reg) : '0;
                            my_reg        <= have_prev_reg ? FIELD_W'(py_reg) : '0;
                            mw_reg        <= have_prev_reg ? FIELD_W'(pw_reg) : '0;
                            mh_reg        <= have_prev_reg ? FIELD_W'(ph_reg) : '0;
                            have_prev_reg <= 1'b0;
                            count_reg     <= '0;
                            ovf_reg       <= 1'b0;
                            state_reg     <= S_COLLECT;
                        end
                    end else if (have_prev_reg) begin
                        if (out_free) begin
                            m_tlast_reg   <= 1'b0;
                            m_bv_reg      <= 1'b1;
                            m_ovf_reg     <= ovf_reg;
                            mx_reg        <= FIELD_W'(px_reg);
                            my_reg        <= FIELD_W'(py_reg);
                            mw_reg        <= FIELD_W'(pw_reg);
                            mh_reg        <= FIELD_W'(ph_reg);
                            have_prev_reg <= 1'b0;
                        end
                    end else begin
                        state_reg <= S_PICK_RD;
                    end
                end
                S_PICK_RD: begin
                    state_reg <= S_PICK_LD;
                end
                S_PICK_LD: begin
                    px_reg        <= rd_x;
                    py_reg        <= rd_y;
                    pw_reg        <= rd_w;
                    ph_reg        <= rd_h;
                    have_prev_reg <= 1'b1;
                    state_reg     <= S_SUP_AREA;
                end
                S_SUP_AREA: begin
                    area_a_reg <= prod[AW-1:0];
                    j_reg      <= '0;
                    state_reg  <= S_SUP_RD;
                end
                S_SUP_RD: begin
                    if (j_reg == count_reg) begin
                        j_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL_RD;
                    end else begin
                        state_reg <= S_SUP_GEO;
                    end
                end
                S_SUP_GEO: begin
                    if (!alive_rd) begin
                        j_reg     <= j_reg + CNTW'(1);
                        state_reg <= S_SUP_RD;
                    end else begin
                        ox_reg    <= overlap(px_reg, pw_reg, rd_x, rd_w);
                        oy_reg    <= overlap(py_reg, ph_reg, rd_y, rd_h);
                        state_reg <= S_SUP_M1;
                    end
                end
                S_SUP_M1: begin
                    area_b_reg <= prod[AW-1:0];
                    state_reg  <= S_SUP_M2;
                end
                S_SUP_M2: begin
                    inter_reg <= prod[AW-1:0];
                    uni_reg   <= UW'(area_a_reg) + UW'(area_b_reg) - UW'(prod[AW-1:0]);
                    state_reg <= S_SUP_M3;
                end
                S_SUP_M3: begin
                    state_reg <= S_SUP_CMP;
                end
                S_SUP_CMP: begin
                    j_reg     <= j_reg + CNTW'(1);
                    state_reg <= S_SUP_RD;
                end
                default: begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {mh_reg, mw_reg, my_reg, mx_reg};
    assign m_tuser  = {m_ovf_reg, m_bv_reg};
endmodule
`default_nettype wire

// File: hdl/mtn_checker.sv
// Port-level checker for the match threshold NMS block, bound to the top level.
`default_nettype none
module mtn_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mtn_pkg::ODATA_W-1:0]   m_tdata,
    input wire logic [mtn_pkg::OUSER_W-1:0]   m_tuser,
    input wire logic                          m_tlast
);
    import mtn_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output transfer changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during suppression");
endmodule

bind match_threshold_nms mtn_checker u_mtn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
